[rtl/core/lidar_point_to_pixel_projection_macros.svh]
// Assertion macros used by the checker file.
`ifndef LIDAR_POINT_TO_PIXEL_PROJECTION_MACROS_SVH
`define LIDAR_POINT_TO_PIXEL_PROJECTION_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LPP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define LPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/lpp_pkg.sv]
// ----------------------------------------------------------------------------
// lpp_pkg
// Types, constants and width helpers for the lidar point projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpp_pkg;

	localparam int POINT_WIDTH_DEF = 24;
	localparam int PIXEL_WIDTH_DEF = 20;
	localparam int COEF_W          = 32;
	localparam int ROWS            = 3;
	localparam int COLS            = 4;
	localparam int FRAC_SHIFT      = 8;   // Q.24 product back to Q.16
	localparam int SUB_PIX         = 4;   // Q16.4 output
	localparam int DEPTH_W         = 24;
	localparam int EXT_W           = 32;
	localparam int DIM_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int MIN_QB          = 21;  // covers width*16 with a 16-bit width
	localparam logic [DEPTH_W-1:0] MIN_DEPTH_RESET = 24'd512;

	typedef logic [ROWS-1:0][COLS-1:0][COEF_W-1:0] coef_mat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_R0_C01  = 3'd0,
		CFG_R0_C23  = 3'd1,
		CFG_R1_C01  = 3'd2,
		CFG_R1_C23  = 3'd3,
		CFG_R2_C01  = 3'd4,
		CFG_R2_C23  = 3'd5,
		CFG_EXTENT  = 3'd6,
		CFG_MIN_DEP = 3'd7
	} cfg_idx_t;

	// accumulator width of one row sum
	function automatic int acc_width(input int pw);
		return COEF_W + pw - FRAC_SHIFT + 2;
	endfunction

	// quotient magnitude bits kept by the divider
	function automatic int quo_width(input int pixw);
		return (pixw > MIN_QB) ? pixw : MIN_QB;
	endfunction

endpackage

`default_nettype wire

[rtl/core/lidar_point_to_pixel_projection.sv]
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_projection
// Projects lidar points through a 3x4 Q16.16 matrix onto image pixels.
//
//  channel | dir | handshake             | payload
//  s_*     | in  | s_tvalid / s_tready   | tdata: point_x, point_y, point_z
//  m_*     | out | m_tvalid / m_tready   | tdata: pixel_u, pixel_v, depth;
//          |     |                       | tuser: in_view
//  cfg_*   | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One point per cycle unless the output stalls. The pipe has three matrix
// stages, QB+1 divider stages (QB = max(PIXEL_WIDTH, 21)) and one output reg.
// Points at or behind zero depth or below the minimum depth leave the pipe at stage three.
// Each stage holds only while its successor is full and stalled, so bubbles
// close up under back-pressure. Reset clears the valid bits, the matrix and
// the extent, and sets the minimum depth to MIN_DEPTH_RESET.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_to_pixel_projection #(
	parameter int POINT_WIDTH = lpp_pkg::POINT_WIDTH_DEF,
	parameter int PIXEL_WIDTH = lpp_pkg::PIXEL_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// point_x, point_y, point_z
	input  wire logic [((3*POINT_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// pixel_u, pixel_v, depth
	output logic [((2*PIXEL_WIDTH+lpp_pkg::DEPTH_W+7)/8)*8-1:0] m_tdata,
	// in_view
	output logic                                        m_tuser,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [lpp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [lpp_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int PW    = POINT_WIDTH;
	localparam int HW    = lpp_pkg::acc_width(PW);
	localparam int MW    = HW + lpp_pkg::SUB_PIX;
	localparam int QB    = lpp_pkg::quo_width(PIXEL_WIDTH);
	localparam int OUT_W = ((2*PIXEL_WIDTH+lpp_pkg::DEPTH_W+7)/8)*8;
	localparam int CW    = lpp_pkg::COEF_W;

	lpp_pkg::coef_mat_t          coef_q;
	logic [lpp_pkg::EXT_W-1:0]   extent_q;
	logic [lpp_pkg::DEPTH_W-1:0] min_depth_q;

	logic                        f_valid, f_ready;
	logic [MW-1:0]               f_nu, f_nv;
	logic                        f_neg_u, f_neg_v;
	logic [HW-1:0]               f_den;
	logic [lpp_pkg::DEPTH_W-1:0] f_depth;

	logic                        d_valid, d_ready;
	logic [QB-1:0]               d_qu, d_qv;
	logic                        d_rnz_u, d_rnz_v, d_ovf_u, d_ovf_v, d_neg_u, d_neg_v;
	logic [lpp_pkg::DEPTH_W-1:0] d_depth;

	logic signed [PIXEL_WIDTH-1:0] pixel_u, pixel_v;
	logic [lpp_pkg::DEPTH_W-1:0]   depth;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q      <= '0;
			extent_q    <= '0;
			min_depth_q <= lpp_pkg::MIN_DEPTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				lpp_pkg::CFG_R0_C01, lpp_pkg::CFG_R0_C23, lpp_pkg::CFG_R1_C01,
				lpp_pkg::CFG_R1_C23, lpp_pkg::CFG_R2_C01, lpp_pkg::CFG_R2_C23: begin
					coef_q[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[2*CW-1:CW];
					coef_q[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[CW-1:0];
				end
				lpp_pkg::CFG_EXTENT:  extent_q    <= cfg_data[lpp_pkg::EXT_W-1:0];
				lpp_pkg::CFG_MIN_DEP: min_depth_q <= cfg_data[lpp_pkg::DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	lpp_front #(.POINT_WIDTH(POINT_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_x      ($signed(s_tdata[PW-1:0])),
		.in_y      ($signed(s_tdata[2*PW-1:PW])),
		.in_z      ($signed(s_tdata[3*PW-1:2*PW])),
		.coef      (coef_q),
		.min_depth (min_depth_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_nu    (f_nu),
		.out_nv    (f_nv),
		.out_neg_u (f_neg_u),
		.out_neg_v (f_neg_v),
		.out_den   (f_den),
		.out_depth (f_depth)
	);

	lpp_div #(.POINT_WIDTH(POINT_WIDTH), .PIXEL_WIDTH(PIXEL_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_nu     (f_nu),
		.in_nv     (f_nv),
		.in_neg_u  (f_neg_u),
		.in_neg_v  (f_neg_v),
		.in_den    (f_den),
		.in_depth  (f_depth),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_qu    (d_qu),
		.out_qv    (d_qv),
		.out_rnz_u (d_rnz_u),
		.out_rnz_v (d_rnz_v),
		.out_ovf_u (d_ovf_u),
		.out_ovf_v (d_ovf_v),
		.out_neg_u (d_neg_u),
		.out_neg_v (d_neg_v),
		.out_depth (d_depth)
	);

	lpp_back #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (d_valid),
		.in_ready    (d_ready),
		.in_qu       (d_qu),
		.in_qv       (d_qv),
		.in_rnz_u    (d_rnz_u),
		.in_rnz_v    (d_rnz_v),
		.in_ovf_u    (d_ovf_u),
		.in_ovf_v    (d_ovf_v),
		.in_neg_u    (d_neg_u),
		.in_neg_v    (d_neg_v),
		.in_depth    (d_depth),
		.extent      (extent_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_u       (pixel_u),
		.out_v       (pixel_v),
		.out_depth   (depth),
		.out_in_view (m_tuser)
	);

	assign m_tdata = OUT_W'({depth, pixel_v, pixel_u});

endmodule

`default_nettype wire

[rtl/core/lpp_front.sv]
// ----------------------------------------------------------------------------
// lpp_front
// Matrix multiply in three stages: products, row sums, depth test and
// divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_front #(
	parameter int POINT_WIDTH = lpp_pkg::POINT_WIDTH_DEF
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            in_valid,
	output logic                                                 in_ready,
	input  wire logic signed [POINT_WIDTH-1:0]                   in_x,
	input  wire logic signed [POINT_WIDTH-1:0]                   in_y,
	input  wire logic signed [POINT_WIDTH-1:0]                   in_z,
	input  wire lpp_pkg::coef_mat_t                              coef,
	input  wire logic [lpp_pkg::DEPTH_W-1:0]                     min_depth,
	output logic                                                 out_valid,
	input  wire logic                                            out_ready,
	output logic [lpp_pkg::acc_width(POINT_WIDTH)+3:0]           out_nu,
	output logic [lpp_pkg::acc_width(POINT_WIDTH)+3:0]           out_nv,
	output logic                                                 out_neg_u,
	output logic                                                 out_neg_v,
	output logic [lpp_pkg::acc_width(POINT_WIDTH)-1:0]           out_den,
	output logic [lpp_pkg::DEPTH_W-1:0]                          out_depth
);

	localparam int PW     = POINT_WIDTH;
	localparam int PROD_W = lpp_pkg::COEF_W + PW;
	localparam int HW     = lpp_pkg::acc_width(PW);
	localparam int MW     = HW + lpp_pkg::SUB_PIX;

	logic signed [PW-1:0]     pt [3];
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic                     v_s1, v_s2, v_s3;
	logic signed [HW-1:0]     h_d [3];
	logic signed [HW-1:0]     h_s2 [3];
	logic                     en1, en2, en3;
	logic signed [HW-1:0]     min_ext;
	logic                     keep;
	logic [HW-1:0]            mag_u, mag_v;
	logic [lpp_pkg::DEPTH_W-1:0] dep_d;

	assign pt[0] = in_x;
	assign pt[1] = in_y;
	assign pt[2] = in_z;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2 && keep;
		end
	end

	// stage 1: nine 32 x POINT_WIDTH products
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(coef[r][c]) * pt[c];
				end
			end
		end
	end

	// stage 2: floor each product to Q.16 and add the translation term
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			h_d[r] = HW'($signed(coef[r][3]));
			for (int c = 0; c < 3; c++) begin
				h_d[r] = h_d[r] + HW'(prod_s1[r][c] >>> lpp_pkg::FRAC_SHIFT);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int r = 0; r < 3; r++) begin
				h_s2[r] <= h_d[r];
			end
		end
	end

	// stage 3: depth gate, saturated depth, sign/magnitude numerators
	assign min_ext = $signed({{(HW-lpp_pkg::DEPTH_W-lpp_pkg::FRAC_SHIFT){1'b0}},
		min_depth, {lpp_pkg::FRAC_SHIFT{1'b0}}});
	assign keep    = (h_s2[2] > 0) && (h_s2[2] >= min_ext);
	assign mag_u   = h_s2[0][HW-1] ? HW'(-h_s2[0]) : HW'(h_s2[0]);
	assign mag_v   = h_s2[1][HW-1] ? HW'(-h_s2[1]) : HW'(h_s2[1]);
	assign dep_d   = (h_s2[2][HW-1:lpp_pkg::DEPTH_W+lpp_pkg::FRAC_SHIFT] != '0)
		? {lpp_pkg::DEPTH_W{1'b1}}
		: h_s2[2][lpp_pkg::DEPTH_W+lpp_pkg::FRAC_SHIFT-1:lpp_pkg::FRAC_SHIFT];

	always_ff @(posedge clk) begin
		if (en3) begin
			out_nu    <= MW'({mag_u, {lpp_pkg::SUB_PIX{1'b0}}});
			out_nv    <= MW'({mag_v, {lpp_pkg::SUB_PIX{1'b0}}});
			out_neg_u <= h_s2[0][HW-1];
			out_neg_v <= h_s2[1][HW-1];
			out_den   <= HW'(h_s2[2]);
			out_depth <= dep_d;
		end
	end

	assign out_valid = v_s3;

endmodule

`default_nettype wire

[rtl/core/lpp_div.sv]
// ----------------------------------------------------------------------------
// lpp_div
// Pipelined restoring divider, one quotient bit in each stage after stage 0,
// u and v side by side over the shared depth divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_div #(
	parameter int POINT_WIDTH = lpp_pkg::POINT_WIDTH_DEF,
	parameter int PIXEL_WIDTH = lpp_pkg::PIXEL_WIDTH_DEF
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            in_valid,
	output logic                                                 in_ready,
	input  wire logic [lpp_pkg::acc_width(POINT_WIDTH)+3:0]      in_nu,
	input  wire logic [lpp_pkg::acc_width(POINT_WIDTH)+3:0]      in_nv,
	input  wire logic                                            in_neg_u,
	input  wire logic                                            in_neg_v,
	input  wire logic [lpp_pkg::acc_width(POINT_WIDTH)-1:0]      in_den,
	input  wire logic [lpp_pkg::DEPTH_W-1:0]                     in_depth,
	output logic                                                 out_valid,
	input  wire logic                                            out_ready,
	output logic [lpp_pkg::quo_width(PIXEL_WIDTH)-1:0]           out_qu,
	output logic [lpp_pkg::quo_width(PIXEL_WIDTH)-1:0]           out_qv,
	output logic                                                 out_rnz_u,
	output logic                                                 out_rnz_v,
	output logic                                                 out_ovf_u,
	output logic                                                 out_ovf_v,
	output logic                                                 out_neg_u,
	output logic                                                 out_neg_v,
	output logic [lpp_pkg::DEPTH_W-1:0]                          out_depth
);

	localparam int HW = lpp_pkg::acc_width(POINT_WIDTH);
	localparam int MW = HW + lpp_pkg::SUB_PIX;
	localparam int RW = HW + 1;
	localparam int QB = lpp_pkg::quo_width(PIXEL_WIDTH);

	logic [RW-1:0]               rem_u_s [QB+1];
	logic [RW-1:0]               rem_v_s [QB+1];
	logic [QB-1:0]               qn_u_s  [QB+1];
	logic [QB-1:0]               qn_v_s  [QB+1];
	logic [HW-1:0]               den_s   [QB+1];
	logic                        negu_s  [QB+1];
	logic                        negv_s  [QB+1];
	logic                        ovfu_s  [QB+1];
	logic                        ovfv_s  [QB+1];
	logic [lpp_pkg::DEPTH_W-1:0] dep_s   [QB+1];
	logic [QB:0]                 v_s;
	logic [QB+1:0]               en;

	assign en[QB+1]  = out_ready;
	assign in_ready  = en[0];
	assign out_valid = v_s[QB];

	// stage 0: high part becomes the first partial remainder; a high part not
	// below the divisor means the quotient does not fit in QB bits
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_u_s[0] <= RW'(in_nu >> QB);
			rem_v_s[0] <= RW'(in_nv >> QB);
			qn_u_s[0]  <= in_nu[QB-1:0];
			qn_v_s[0]  <= in_nv[QB-1:0];
			ovfu_s[0]  <= (in_nu >> QB) >= MW'(in_den);
			ovfv_s[0]  <= (in_nv >> QB) >= MW'(in_den);
			den_s[0]   <= in_den;
			negu_s[0]  <= in_neg_u;
			negv_s[0]  <= in_neg_v;
			dep_s[0]   <= in_depth;
		end
	end

	genvar k;
	generate
		for (k = 0; k <= QB; k++) begin : g_ctl
			assign en[k] = !v_s[k] || en[k+1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					if (k == 0) v_s[k] <= in_valid;
					else        v_s[k] <= v_s[k == 0 ? 0 : k-1];
				end
			end
		end

		for (k = 1; k <= QB; k++) begin : g_step
			logic [RW-1:0] tu, tv;
			logic          geu, gev;
			// qn holds the unused dividend bits, quotient bits shift in below
			always_comb begin
				tu  = {rem_u_s[k-1][RW-2:0], qn_u_s[k-1][QB-1]};
				tv  = {rem_v_s[k-1][RW-2:0], qn_v_s[k-1][QB-1]};
				geu = tu >= RW'(den_s[k-1]);
				gev = tv >= RW'(den_s[k-1]);
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_u_s[k] <= geu ? tu - RW'(den_s[k-1]) : tu;
					rem_v_s[k] <= gev ? tv - RW'(den_s[k-1]) : tv;
					qn_u_s[k]  <= {qn_u_s[k-1][QB-2:0], geu};
					qn_v_s[k]  <= {qn_v_s[k-1][QB-2:0], gev};
					ovfu_s[k]  <= ovfu_s[k-1];
					ovfv_s[k]  <= ovfv_s[k-1];
					den_s[k]   <= den_s[k-1];
					negu_s[k]  <= negu_s[k-1];
					negv_s[k]  <= negv_s[k-1];
					dep_s[k]   <= dep_s[k-1];
				end
			end
		end
	endgenerate

	assign out_qu    = qn_u_s[QB];
	assign out_qv    = qn_v_s[QB];
	assign out_rnz_u = rem_u_s[QB] != '0;
	assign out_rnz_v = rem_v_s[QB] != '0;
	assign out_ovf_u = ovfu_s[QB];
	assign out_ovf_v = ovfv_s[QB];
	assign out_neg_u = negu_s[QB];
	assign out_neg_v = negv_s[QB];
	assign out_depth = dep_s[QB];

endmodule

`default_nettype wire

[rtl/core/lpp_back.sv]
// ----------------------------------------------------------------------------
// lpp_back
// Floor correction, saturation and image bounds test into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_back #(
	parameter int PIXEL_WIDTH = lpp_pkg::PIXEL_WIDTH_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_ready,
	input  wire logic [lpp_pkg::quo_width(PIXEL_WIDTH)-1:0] in_qu,
	input  wire logic [lpp_pkg::quo_width(PIXEL_WIDTH)-1:0] in_qv,
	input  wire logic                                       in_rnz_u,
	input  wire logic                                       in_rnz_v,
	input  wire logic                                       in_ovf_u,
	input  wire logic                                       in_ovf_v,
	input  wire logic                                       in_neg_u,
	input  wire logic                                       in_neg_v,
	input  wire logic [lpp_pkg::DEPTH_W-1:0]                in_depth,
	input  wire logic [lpp_pkg::EXT_W-1:0]                  extent,
	output logic                                            out_valid,
	input  wire logic                                       out_ready,
	output logic signed [PIXEL_WIDTH-1:0]                   out_u,
	output logic signed [PIXEL_WIDTH-1:0]                   out_v,
	output logic [lpp_pkg::DEPTH_W-1:0]                     out_depth,
	output logic                                            out_in_view
);

	localparam int QB = lpp_pkg::quo_width(PIXEL_WIDTH);
	localparam int QS = QB + 1;
	localparam logic signed [QS-1:0] HI = {{(QS-PIXEL_WIDTH+1){1'b0}}, {(PIXEL_WIDTH-1){1'b1}}};
	localparam logic signed [QS-1:0] LO = {{(QS-PIXEL_WIDTH+1){1'b1}}, {(PIXEL_WIDTH-1){1'b0}}};

	logic                        en;
	logic                        v_q;
	logic signed [QS-1:0]        qu_d, qv_d;
	logic [QS-1:0]               w16, h16;

	// signed floor quotient from magnitude, sign and remainder
	function automatic logic signed [QS-1:0] floor_q(input logic [QB-1:0] q,
		input logic neg, input logic rnz);
		logic signed [QS-1:0] mag;
		mag = $signed({1'b0, q});
		if (neg) return -mag - QS'(rnz);
		return mag;
	endfunction

	function automatic logic [PIXEL_WIDTH-1:0] sat_q(input logic signed [QS-1:0] q,
		input logic ovf, input logic neg);
		logic signed [QS-1:0] s;
		if (ovf)          s = neg ? LO : HI;
		else if (q > HI)  s = HI;
		else if (q < LO)  s = LO;
		else              s = q;
		return s[PIXEL_WIDTH-1:0];
	endfunction

	assign qu_d = floor_q(in_qu, in_neg_u, in_rnz_u);
	assign qv_d = floor_q(in_qv, in_neg_v, in_rnz_v);
	assign w16  = QS'({extent[lpp_pkg::EXT_W-1:lpp_pkg::DIM_W], {lpp_pkg::SUB_PIX{1'b0}}});
	assign h16  = QS'({extent[lpp_pkg::DIM_W-1:0], {lpp_pkg::SUB_PIX{1'b0}}});

	assign en       = !v_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_u       <= sat_q(qu_d, in_ovf_u, in_neg_u);
			out_v       <= sat_q(qv_d, in_ovf_v, in_neg_v);
			out_depth   <= in_depth;
			// an overflowed quotient is far beyond any 16-bit image extent
			out_in_view <= !in_ovf_u && !in_ovf_v && !qu_d[QS-1] && !qv_d[QS-1]
				&& (qu_d < w16) && (qv_d < h16);
		end
	end

	assign out_valid = v_q;

endmodule

`default_nettype wire

[rtl/core/lpp_checker.sv]
// ----------------------------------------------------------------------------
// lpp_checker
// Port-level checks on the projection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_point_to_pixel_projection_macros.svh"

module lpp_checker #(
	parameter int PIXEL_WIDTH = lpp_pkg::PIXEL_WIDTH_DEF
) (
	input wire logic                                                    clk,
	input wire logic                                                    arst_n,
	input wire logic                                                    s_tready,
	input wire logic                                                    m_tvalid,
	input wire logic                                                    m_tready,
	input wire logic [((2*PIXEL_WIDTH+lpp_pkg::DEPTH_W+7)/8)*8-1:0]     m_tdata,
	input wire logic                                                    m_tuser
);

	// empty output register means every stage can move
	`LPP_ASSERT_IMP(a_empty_takes, !m_tvalid, s_tready, "input stalled with empty output")

	// an in-view pixel has non-negative u and v
	`LPP_ASSERT_IMP(a_view_sign, m_tvalid && m_tuser,
		!m_tdata[PIXEL_WIDTH-1] && !m_tdata[2*PIXEL_WIDTH-1], "in_view with negative pixel")

	`LPP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind lidar_point_to_pixel_projection lpp_checker #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_lpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
